// File: rtl/nfba_pkg.sv
// ----------------------------------------------------------------------------
// nfba_pkg: shared types and constants of the next-fit block allocator
// Field widths, operation and status codes, and the response struct.
// ----------------------------------------------------------------------------
package nfba_pkg;

  localparam int DEF_NUM_BLOCKS  = 127;
  localparam int DEF_BLOCK_BYTES = 16;

  localparam int OP_W       = 2;
  localparam int REQ_W      = 11;
  localparam int ADDR_W     = 11;
  localparam int BLK_W      = 7;
  localparam int STAT_W     = 2;
  localparam int HDR_W      = 8;
  localparam int HDR_MAX    = 127;
  localparam int TOTAL_W    = HDR_W + 1;
  localparam int DIVIDEND_W = REQ_W + 1;
  localparam int TDATA_W    = 24;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC    = 2'd0,
    OP_FREE     = 2'd1,
    OP_COALESCE = 2'd2
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_NOSPACE  = 2'd1,
    ST_BADSIZE  = 2'd2,
    ST_NOTALLOC = 2'd3
  } status_t;

  typedef struct packed {
    logic              valid;
    status_t           status;
    logic [ADDR_W-1:0] addr;
    logic [BLK_W-1:0]  blocks;
  } resp_t;

endpackage

// File: rtl/nfba_map_mem.sv
// ----------------------------------------------------------------------------
// nfba_map_mem: segment header map
// One write port and one registered read port; per-entry valid bits give
// the reset image (first entry holds the block count, the rest zero).
// ----------------------------------------------------------------------------
module nfba_map_mem
  import nfba_pkg::*;
#(
  parameter int NUM_BLOCKS = DEF_NUM_BLOCKS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          rd_en,
  input  logic [$clog2(NUM_BLOCKS)-1:0] rd_addr,
  output logic [HDR_W-1:0]              rd_data,
  input  logic                          wr_en,
  input  logic [$clog2(NUM_BLOCKS)-1:0] wr_addr,
  input  logic [HDR_W-1:0]              wr_data
);

  localparam int AW = $clog2(NUM_BLOCKS);

  logic [HDR_W-1:0]      mem [NUM_BLOCKS];
  logic [NUM_BLOCKS-1:0] vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (vld[rd_addr]) begin
        rd_data <= mem[rd_addr];
      end else if (rd_addr == AW'(0)) begin
        rd_data <= HDR_W'(NUM_BLOCKS);
      end else begin
        rd_data <= '0;
      end
    end
  end

endmodule

// File: rtl/nfba_div.sv
// ----------------------------------------------------------------------------
// nfba_div: divider by the block size
// Multiplies by a fixed-point reciprocal of the block size; the quotient is
// ready in the cycle after start and must fit QW bits.
// ----------------------------------------------------------------------------
module nfba_div
  import nfba_pkg::*;
#(
  parameter int BLOCK_BYTES = DEF_BLOCK_BYTES,
  parameter int QW          = 7
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  output logic                  done,
  output logic [QW-1:0]         quot
);

  localparam int SH = DIVIDEND_W + $clog2(BLOCK_BYTES);
  localparam int MW = DIVIDEND_W + 2;
  localparam int PW = DIVIDEND_W + MW;
  localparam logic [MW-1:0] RECIP = MW'(((1 << SH) + BLOCK_BYTES - 1) / BLOCK_BYTES);

  logic [PW-1:0] prod;

  assign prod = PW'(dividend) * PW'(RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= start;
    end
    if (start) begin
      quot <= QW'(prod >> SH);
    end
  end

endmodule

// File: rtl/nfba_seq.sv
// ----------------------------------------------------------------------------
// nfba_seq: allocator sequencer
// Walks the header map next-fit, splits, frees and merges free runs with
// one map read and one map write per cycle.
// ----------------------------------------------------------------------------
module nfba_seq
  import nfba_pkg::*;
#(
  parameter int NUM_BLOCKS  = DEF_NUM_BLOCKS,
  parameter int BLOCK_BYTES = DEF_BLOCK_BYTES
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [OP_W-1:0]                       in_op,
  input  logic [REQ_W-1:0]                      in_req,
  input  logic [ADDR_W-1:0]                     in_addr,
  input  logic                                  coalesce_on_fail,
  output resp_t                                 resp,
  input  logic                                  resp_ready,
  output logic                                  div_start,
  output logic [DIVIDEND_W-1:0]                 div_dividend,
  input  logic                                  div_done,
  input  logic [$clog2(NUM_BLOCKS+1)-1:0]       div_quot,
  output logic                                  rd_en,
  output logic [$clog2(NUM_BLOCKS)-1:0]         rd_addr,
  input  logic [HDR_W-1:0]                      rd_data,
  output logic                                  wr_en,
  output logic [$clog2(NUM_BLOCKS)-1:0]         wr_addr,
  output logic [HDR_W-1:0]                      wr_data
);

  localparam int AW  = $clog2(NUM_BLOCKS);
  localparam int QW  = $clog2(NUM_BLOCKS + 1);
  localparam int BW  = $clog2(BLOCK_BYTES + 1);
  localparam int SW  = ((AW > QW) ? AW : QW) + 1;
  localparam int IW  = ((AW > HDR_W - 1) ? AW : HDR_W - 1) + 1;
  localparam int PW  = AW + BW;
  localparam int CMP_W = 16;
  localparam logic [CMP_W-1:0] HEAP_BYTES = CMP_W'(BLOCK_BYTES * NUM_BLOCKS);
  localparam logic [AW-1:0]    LAST = AW'(NUM_BLOCKS - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_WSTART, S_WALK, S_SPLIT, S_FCHK,
    S_MSTART, S_MSCAN, S_MFIN, S_RESP
  } state_t;

  state_t              state, state_next;
  logic [QW-1:0]       need, need_next;
  logic [AW-1:0]       ptr, ptr_next;
  logic [AW-1:0]       cnt, cnt_next;
  logic                retried, retried_next;
  logic                is_alloc, is_alloc_next;
  logic [AW-1:0]       idx, idx_next;
  logic                in_run, in_run_next;
  logic [AW-1:0]       head, head_next;
  logic [TOTAL_W-1:0]  total, total_next;
  logic [AW-1:0]       split_addr, split_addr_next;
  logic [HDR_W-1:0]    split_val, split_val_next;
  status_t             res_status, res_status_next;
  logic [ADDR_W-1:0]   res_addr, res_addr_next;
  logic [BLK_W-1:0]    res_blocks, res_blocks_next;

  logic                h_pos;
  logic [HDR_W-2:0]    hlen;
  logic                hit;
  logic [SW-1:0]       walk_sum;
  logic [AW-1:0]       walk_wrap;
  logic [AW-1:0]       ptr_inc;
  logic [IW-1:0]       scan_sum;
  logic [HDR_W-1:0]    total_cap;
  logic [PW-1:0]       gaddr_prod;
  logic [CMP_W-1:0]    req_w;
  logic [CMP_W-1:0]    addr_w;

  assign h_pos      = !rd_data[HDR_W-1] && (rd_data != '0);
  assign hlen       = rd_data[HDR_W-2:0];
  assign hit        = h_pos && (HDR_W'(hlen) >= HDR_W'(need));
  assign walk_sum   = SW'(ptr) + SW'(need);
  assign walk_wrap  = (walk_sum >= SW'(NUM_BLOCKS)) ? AW'(walk_sum - SW'(NUM_BLOCKS))
                                                    : AW'(walk_sum);
  assign ptr_inc    = (ptr == LAST) ? '0 : ptr + AW'(1);
  assign scan_sum   = h_pos ? IW'(idx) + IW'(hlen) : IW'(idx) + IW'(1);
  assign total_cap  = (total > TOTAL_W'(HDR_MAX)) ? HDR_W'(HDR_MAX) : total[HDR_W-1:0];
  assign gaddr_prod = PW'(ptr) * PW'(BLOCK_BYTES);
  assign req_w      = CMP_W'(in_req);
  assign addr_w     = CMP_W'(in_addr);

  always_comb begin
    state_next      = state;
    need_next       = need;
    ptr_next        = ptr;
    cnt_next        = cnt;
    retried_next    = retried;
    is_alloc_next   = is_alloc;
    idx_next        = idx;
    in_run_next     = in_run;
    head_next       = head;
    total_next      = total;
    split_addr_next = split_addr;
    split_val_next  = split_val;
    res_status_next = res_status;
    res_addr_next   = res_addr;
    res_blocks_next = res_blocks;
    in_ready        = 1'b0;
    div_start       = 1'b0;
    div_dividend    = '0;
    rd_en           = 1'b0;
    rd_addr         = ptr;
    wr_en           = 1'b0;
    wr_addr         = ptr;
    wr_data         = '0;
    resp            = '{valid: 1'b0, status: res_status, addr: res_addr,
                        blocks: res_blocks};

    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          res_status_next = ST_OK;
          res_addr_next   = '0;
          res_blocks_next = '0;
          retried_next    = 1'b0;
          is_alloc_next   = 1'b0;
          case (op_t'(in_op))
            OP_ALLOC: begin
              is_alloc_next = 1'b1;
              if (in_req == '0 || req_w > HEAP_BYTES) begin
                res_status_next = ST_BADSIZE;
                state_next      = S_RESP;
              end else begin
                div_start    = 1'b1;
                div_dividend = DIVIDEND_W'(in_req) + DIVIDEND_W'(BLOCK_BYTES - 1);
                state_next   = S_DIV;
              end
            end
            OP_FREE: begin
              if (addr_w >= HEAP_BYTES) begin
                res_status_next = ST_NOTALLOC;
                state_next      = S_RESP;
              end else begin
                div_start    = 1'b1;
                div_dividend = DIVIDEND_W'(in_addr);
                state_next   = S_DIV;
              end
            end
            OP_COALESCE: begin
              state_next = S_MSTART;
            end
            default: begin
              state_next = S_RESP;
            end
          endcase
        end
      end

      S_DIV: begin
        if (div_done) begin
          need_next = div_quot;
          if (is_alloc) begin
            state_next = S_WSTART;
          end else begin
            rd_en      = 1'b1;
            rd_addr    = AW'(div_quot);
            state_next = S_FCHK;
          end
        end
      end

      S_WSTART: begin
        rd_en      = 1'b1;
        rd_addr    = ptr;
        cnt_next   = '0;
        state_next = S_WALK;
      end

      S_WALK: begin
        if (hit) begin
          wr_en           = 1'b1;
          wr_addr         = ptr;
          wr_data         = HDR_W'(0) - HDR_W'(need);
          ptr_next        = walk_wrap;
          res_addr_next   = ADDR_W'(gaddr_prod);
          res_blocks_next = BLK_W'(need);
          res_status_next = ST_OK;
          if (HDR_W'(hlen) > HDR_W'(need) && walk_sum < SW'(NUM_BLOCKS)) begin
            split_addr_next = AW'(walk_sum);
            split_val_next  = HDR_W'(hlen) - HDR_W'(need);
            state_next      = S_SPLIT;
          end else begin
            state_next = S_RESP;
          end
        end else begin
          ptr_next = ptr_inc;
          cnt_next = cnt + AW'(1);
          if (cnt == LAST) begin
            if (coalesce_on_fail && !retried) begin
              retried_next = 1'b1;
              state_next   = S_MSTART;
            end else begin
              res_status_next = ST_NOSPACE;
              state_next      = S_RESP;
            end
          end else begin
            rd_en   = 1'b1;
            rd_addr = ptr_inc;
          end
        end
      end

      S_SPLIT: begin
        wr_en      = 1'b1;
        wr_addr    = split_addr;
        wr_data    = split_val;
        state_next = S_RESP;
      end

      S_FCHK: begin
        if (rd_data[HDR_W-1]) begin
          wr_en   = 1'b1;
          wr_addr = AW'(need);
          wr_data = HDR_W'(0) - rd_data;
        end else begin
          res_status_next = ST_NOTALLOC;
        end
        state_next = S_RESP;
      end

      S_MSTART: begin
        rd_en       = 1'b1;
        rd_addr     = '0;
        idx_next    = '0;
        in_run_next = 1'b0;
        state_next  = S_MSCAN;
      end

      S_MSCAN: begin
        if (h_pos) begin
          wr_en       = 1'b1;
          wr_addr     = idx;
          wr_data     = '0;
          in_run_next = 1'b1;
          if (!in_run) begin
            head_next  = idx;
            total_next = TOTAL_W'(hlen);
          end else begin
            total_next = total + TOTAL_W'(hlen);
          end
        end else if (in_run) begin
          wr_en       = 1'b1;
          wr_addr     = head;
          wr_data     = total_cap;
          in_run_next = 1'b0;
        end
        if (scan_sum >= IW'(NUM_BLOCKS)) begin
          if (h_pos) begin
            state_next = S_MFIN;
          end else if (is_alloc) begin
            state_next = S_WSTART;
          end else begin
            state_next = S_RESP;
          end
        end else begin
          rd_en    = 1'b1;
          rd_addr  = AW'(scan_sum);
          idx_next = AW'(scan_sum);
        end
      end

      S_MFIN: begin
        wr_en       = 1'b1;
        wr_addr     = head;
        wr_data     = total_cap;
        in_run_next = 1'b0;
        state_next  = is_alloc ? S_WSTART : S_RESP;
      end

      S_RESP: begin
        resp.valid = 1'b1;
        if (resp_ready) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      ptr      <= '0;
      retried  <= 1'b0;
      is_alloc <= 1'b0;
      in_run   <= 1'b0;
    end else begin
      state    <= state_next;
      ptr      <= ptr_next;
      retried  <= retried_next;
      is_alloc <= is_alloc_next;
      in_run   <= in_run_next;
    end
    need       <= need_next;
    cnt        <= cnt_next;
    idx        <= idx_next;
    head       <= head_next;
    total      <= total_next;
    split_addr <= split_addr_next;
    split_val  <= split_val_next;
    res_status <= res_status_next;
    res_addr   <= res_addr_next;
    res_blocks <= res_blocks_next;
  end

endmodule

// File: rtl/next_fit_block_allocator_unit.sv
// ----------------------------------------------------------------------------
// next_fit_block_allocator_unit: next-fit block allocator
// Requests enter on s_axis (op in tuser, sizes in tdata); one response per
// request leaves on m_axis. The cfg channel writes coalesce_on_fail.
//
// Each item is served from the header map, with one read and one write per
// cycle, and a registered reciprocal divide by the block size. An allocate
// divides the size, then walks up to NUM_BLOCKS entries from the walk
// pointer and writes the header, plus one more write when the free run is
// split; a failed walk with coalescing enabled adds a merge pass and a
// second walk. A free divides the address, reads the header and restores
// it if allocated; a coalesce is one merge pass; bad size, out-of-range
// free and unused op go straight to the response.
// One item is processed at a time; s_axis_tready is high while idle, and
// the next item can be accepted in the cycle after the response is loaded.
// The response sits in an output register, so a new item is accepted while
// the receiver stalls; the sequencer holds its next response until it drains.
// Reset clears the map to one free run of NUM_BLOCKS blocks, the walk
// pointer to zero and coalesce_on_fail to one.
// ----------------------------------------------------------------------------
module next_fit_block_allocator_unit
  import nfba_pkg::*;
#(
  parameter int NUM_BLOCKS  = DEF_NUM_BLOCKS,
  parameter int BLOCK_BYTES = DEF_BLOCK_BYTES
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [TDATA_W-1:0] s_axis_tdata,   // req_bytes[10:0], seg_addr[21:11]
  input  logic [OP_W-1:0]    s_axis_tuser,   // op[1:0]
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [TDATA_W-1:0] m_axis_tdata,   // granted_addr[10:0], granted_blocks[17:11]
  output logic [STAT_W-1:0]  m_axis_tuser,   // status[1:0]
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data
);

  localparam int AW = $clog2(NUM_BLOCKS);
  localparam int QW = $clog2(NUM_BLOCKS + 1);

  logic                  coalesce_on_fail;
  resp_t                 resp;
  logic                  resp_ready;
  logic                  div_start;
  logic [DIVIDEND_W-1:0] div_dividend;
  logic                  div_done;
  logic [QW-1:0]         div_quot;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic [HDR_W-1:0]      rd_data;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [HDR_W-1:0]      wr_data;

  assign cfg_ready  = 1'b1;
  assign resp_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      coalesce_on_fail <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      coalesce_on_fail <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (resp_ready) begin
      m_axis_tvalid <= resp.valid;
    end
    if (resp.valid && resp_ready) begin
      m_axis_tdata <= TDATA_W'({resp.blocks, resp.addr});
      m_axis_tuser <= resp.status;
    end
  end

  nfba_seq #(
    .NUM_BLOCKS  (NUM_BLOCKS),
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_seq (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (s_axis_tvalid),
    .in_ready         (s_axis_tready),
    .in_op            (s_axis_tuser),
    .in_req           (s_axis_tdata[REQ_W-1:0]),
    .in_addr          (s_axis_tdata[REQ_W+ADDR_W-1:REQ_W]),
    .coalesce_on_fail (coalesce_on_fail),
    .resp             (resp),
    .resp_ready       (resp_ready),
    .div_start        (div_start),
    .div_dividend     (div_dividend),
    .div_done         (div_done),
    .div_quot         (div_quot),
    .rd_en            (rd_en),
    .rd_addr          (rd_addr),
    .rd_data          (rd_data),
    .wr_en            (wr_en),
    .wr_addr          (wr_addr),
    .wr_data          (wr_data)
  );

  nfba_div #(
    .BLOCK_BYTES (BLOCK_BYTES),
    .QW          (QW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .done     (div_done),
    .quot     (div_quot)
  );

  nfba_map_mem #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_map (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

endmodule

// File: tb/sv/next_fit_block_allocator_unit_test.sv
// ----------------------------------------------------------------------------
// next_fit_block_allocator_unit_test: self-checking bench of the allocator
// A table of directed requests comes first: size limits, exact fits, pointer
// wrap, frees of bad headers and the merge retry in both register settings.
// Random phases follow, alternating the coalesce_on_fail setting. They are
// mostly allocations and frees of live segments, with some noise requests.
// The sender runs in bursts and the receiver stalls on its own pattern.
// Random responses are checked against a behavioral header map model.
// ----------------------------------------------------------------------------
module next_fit_block_allocator_unit_test;
  import nfba_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NBLK        = DEF_NUM_BLOCKS;
  localparam int BBYTES      = DEF_BLOCK_BYTES;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 242;
  localparam int DRAIN_WAIT  = 450;
  localparam int PAD_W       = TDATA_W - REQ_W - ADDR_W;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    status_t           status;
    logic [ADDR_W-1:0] addr;
    logic [BLK_W-1:0]  blocks;
  } grant_t;

  typedef struct packed {
    bit                cfg_row;
    logic [OP_W-1:0]   op;
    logic [REQ_W-1:0]  req;
    logic [ADDR_W-1:0] seg;
    bit                known;
    status_t           st;
    logic [ADDR_W-1:0] g_addr;
    logic [BLK_W-1:0]  g_blocks;
  } plan_row_t;

  typedef enum int {RX_OPEN, RX_COIN, RX_MOSTLY, RX_STARVE} rx_mode_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [TDATA_W-1:0] s_axis_tdata = '0;
  logic [OP_W-1:0]    s_axis_tuser = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [TDATA_W-1:0] m_axis_tdata;
  logic [STAT_W-1:0]  m_axis_tuser;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic               cfg_data = 1'b0;

  logic signed [HDR_W-1:0] hdr_map [NBLK];
  int unsigned             walk_ptr;
  bit                      merge_on_fail;
  grant_t                  expected_grants [$];
  int                      mismatches = 0;

  plan_row_t plan [28] = '{
    '{1'b1, OP_ALLOC,    11'd1,    11'd0,    1'b0, ST_OK,       11'd0,  7'd0},
    '{1'b0, OP_ALLOC,    11'd0,    11'd0,    1'b1, ST_BADSIZE,  11'd0,  7'd0},
    '{1'b0, OP_ALLOC,    11'd2047, 11'd0,    1'b1, ST_BADSIZE,  11'd0,  7'd0},
    '{1'b0, OP_ALLOC,    11'd2033, 11'd0,    1'b1, ST_BADSIZE,  11'd0,  7'd0},
    '{1'b0, OP_ALLOC,    11'd2032, 11'd0,    1'b1, ST_OK,       11'd0,  7'd127},
    '{1'b0, OP_ALLOC,    11'd1,    11'd0,    1'b1, ST_NOSPACE,  11'd0,  7'd0},
    '{1'b0, OP_FREE,     11'd0,    11'd2047, 1'b1, ST_NOTALLOC, 11'd0,  7'd0},
    '{1'b0, OP_FREE,     11'd0,    11'd2031, 1'b1, ST_NOTALLOC, 11'd0,  7'd0},
    '{1'b0, OP_FREE,     11'd2047, 11'd0,    1'b1, ST_OK,       11'd0,  7'd0},
    '{1'b0, OP_FREE,     11'd0,    11'd0,    1'b1, ST_NOTALLOC, 11'd0,  7'd0},
    '{1'b0, OP_UNUSED,   11'd2047, 11'd2047, 1'b1, ST_OK,       11'd0,  7'd0},
    '{1'b0, OP_ALLOC,    11'd1,    11'd2047, 1'b1, ST_OK,       11'd0,  7'd1},
    '{1'b0, OP_ALLOC,    11'd17,   11'd0,    1'b1, ST_OK,       11'd16, 7'd2},
    '{1'b0, OP_ALLOC,    11'd48,   11'd0,    1'b1, ST_OK,       11'd48, 7'd3},
    '{1'b0, OP_FREE,     11'd0,    11'd17,   1'b1, ST_OK,       11'd0,  7'd0},
    '{1'b0, OP_FREE,     11'd0,    11'd3,    1'b1, ST_OK,       11'd0,  7'd0},
    '{1'b0, OP_COALESCE, 11'd0,    11'd0,    1'b1, ST_OK,       11'd0,  7'd0},
    '{1'b0, OP_ALLOC,    11'd1936, 11'd0,    1'b1, ST_OK,       11'd96, 7'd121},
    '{1'b0, OP_ALLOC,    11'd64,   11'd0,    1'b1, ST_NOSPACE,  11'd0,  7'd0},
    '{1'b0, OP_ALLOC,    11'd48,   11'd0,    1'b1, ST_OK,       11'd0,  7'd3},
    '{1'b0, OP_FREE,     11'd0,    11'd48,   1'b1, ST_OK,       11'd0,  7'd0},
    '{1'b0, OP_FREE,     11'd0,    11'd96,   1'b1, ST_OK,       11'd0,  7'd0},
    '{1'b1, OP_ALLOC,    11'd0,    11'd0,    1'b0, ST_OK,       11'd0,  7'd0},
    '{1'b0, OP_ALLOC,    11'd1984, 11'd0,    1'b1, ST_NOSPACE,  11'd0,  7'd0},
    '{1'b1, OP_ALLOC,    11'd1,    11'd0,    1'b0, ST_OK,       11'd0,  7'd0},
    '{1'b0, OP_ALLOC,    11'd1984, 11'd0,    1'b1, ST_OK,       11'd48, 7'd124},
    '{1'b0, OP_FREE,     11'd0,    11'd0,    1'b1, ST_OK,       11'd0,  7'd0},
    '{1'b0, OP_FREE,     11'd0,    11'd48,   1'b1, ST_OK,       11'd0,  7'd0}
  };

  next_fit_block_allocator_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always #6 clk = ~clk;

  function automatic void merge_runs();
    int unsigned i;
    int unsigned head;
    int          total;
    int          len;
    i = 0;
    while (i < NBLK) begin
      if (hdr_map[i] > 0) begin
        head  = i;
        total = 0;
        while (i < NBLK && hdr_map[i] > 0) begin
          len        = hdr_map[i];
          total     += len;
          hdr_map[i] = '0;
          i         += len;
        end
        if (total > HDR_MAX) total = HDR_MAX;
        hdr_map[head] = HDR_W'(total);
      end else begin
        i++;
      end
    end
  endfunction

  function automatic bit walk_fit(input int need, output int unsigned where);
    int unsigned p;
    int          h;
    where = 0;
    for (int n = 0; n < NBLK; n++) begin
      p = walk_ptr;
      h = hdr_map[p];
      if (h > 0 && h >= need) begin
        if (h > need && p + need < NBLK) hdr_map[p + need] = HDR_W'(h - need);
        hdr_map[p] = HDR_W'(-need);
        walk_ptr   = (p + need) % NBLK;
        where      = p;
        return 1'b1;
      end
      walk_ptr = (p + 1) % NBLK;
    end
    return 1'b0;
  endfunction

  function automatic grant_t serve_request(input logic [OP_W-1:0] op,
                                           input logic [REQ_W-1:0] req,
                                           input logic [ADDR_W-1:0] seg);
    grant_t      g;
    int          need;
    int unsigned where;
    int unsigned blk;
    bit          ok;
    g.status = ST_OK;
    g.addr   = '0;
    g.blocks = '0;
    case (op)
      OP_ALLOC: begin
        if (req == 0 || req > BBYTES * NBLK) begin
          g.status = ST_BADSIZE;
        end else begin
          need = (req + BBYTES - 1) / BBYTES;
          ok   = walk_fit(need, where);
          if (!ok && merge_on_fail) begin
            merge_runs();
            ok = walk_fit(need, where);
          end
          if (ok) begin
            g.addr   = ADDR_W'(where * BBYTES);
            g.blocks = BLK_W'(need);
          end else begin
            g.status = ST_NOSPACE;
          end
        end
      end
      OP_FREE: begin
        blk = seg / BBYTES;
        if (blk >= NBLK || hdr_map[blk] >= 0) g.status = ST_NOTALLOC;
        else hdr_map[blk] = -hdr_map[blk];
      end
      OP_COALESCE: merge_runs();
      default: ;
    endcase
    return g;
  endfunction

  function automatic void pick_request(output logic [OP_W-1:0] op,
                                       output logic [REQ_W-1:0] req,
                                       output logic [ADDR_W-1:0] seg);
    int unsigned live [$];
    int unsigned roll;
    roll = $urandom_range(0, 99);
    req  = REQ_W'($urandom_range(0, 2047));
    seg  = ADDR_W'($urandom_range(0, 2047));
    if (roll >= 44 && roll < 80) begin
      for (int i = 0; i < NBLK; i++) if (hdr_map[i] < 0) live.push_back(i);
      if (live.size() == 0) roll = 0;
    end
    if (roll < 44) begin
      op = OP_ALLOC;
      case ($urandom_range(0, 19))
        0:       req = REQ_W'($urandom_range(1, BBYTES * NBLK));
        1, 2, 3: req = REQ_W'($urandom_range(1, 800));
        default: req = REQ_W'($urandom_range(1, 160));
      endcase
    end else if (roll < 80) begin
      op  = OP_FREE;
      seg = ADDR_W'(live[$urandom_range(0, live.size() - 1)] * BBYTES
                    + $urandom_range(0, BBYTES - 1));
    end else if (roll < 86) begin
      op = OP_FREE;
    end else if (roll < 92) begin
      op = OP_COALESCE;
    end else if (roll < 97) begin
      op = OP_ALLOC;
    end else begin
      op = OP_UNUSED;
    end
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= 40)
      $display("[%0t] mismatch on %s: got %0d, want %0d", $time, what, got, want);
  endtask

  task automatic send_request(input logic [OP_W-1:0] op, input logic [REQ_W-1:0] req,
                              input logic [ADDR_W-1:0] seg, output grant_t want);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {{PAD_W{1'b0}}, seg, req};
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
    want = serve_request(op, req, seg);
  endtask

  task automatic set_merge_mode(input bit v);
    s_axis_tvalid <= 1'b0;
    while (expected_grants.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid     <= 1'b0;
    merge_on_fail  = v;
  endtask

  always @(posedge clk) begin : check_grants
    grant_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_grants.size() == 0) begin
        report_mismatch("unexpected response status", m_axis_tuser, -1);
      end else begin
        want = expected_grants.pop_front();
        if (m_axis_tuser != want.status)
          report_mismatch("status", m_axis_tuser, want.status);
        if (m_axis_tdata[ADDR_W-1:0] != want.addr)
          report_mismatch("granted_addr", m_axis_tdata[ADDR_W-1:0], want.addr);
        if (m_axis_tdata[ADDR_W+BLK_W-1:ADDR_W] != want.blocks)
          report_mismatch("granted_blocks", m_axis_tdata[ADDR_W+BLK_W-1:ADDR_W],
                          want.blocks);
      end
    end
  end

  initial begin : stall_receiver
    rx_mode_t mode;
    int       span;
    forever begin
      mode = rx_mode_t'($urandom_range(0, 3));
      span = $urandom_range(16, 96);
      repeat (span) begin
        @(posedge clk);
        case (mode)
          RX_OPEN:   m_axis_tready <= 1'b1;
          RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
          RX_MOSTLY: m_axis_tready <= ($urandom_range(0, 7) != 0);
          default:   m_axis_tready <= ($urandom_range(0, 15) == 0);
        endcase
      end
    end
  end

  initial begin : run_limit
    #40_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin : drive_requests
    grant_t            g;
    logic [OP_W-1:0]   op;
    logic [REQ_W-1:0]  req;
    logic [ADDR_W-1:0] seg;
    int                sent;
    int                burst;
    int                gap;
    foreach (hdr_map[i]) hdr_map[i] = '0;
    hdr_map[0]    = HDR_W'(NBLK);
    walk_ptr      = 0;
    merge_on_fail = 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[r]) begin
      if (plan[r].cfg_row) begin
        set_merge_mode(plan[r].req[0]);
      end else begin
        send_request(plan[r].op, plan[r].req, plan[r].seg, g);
        if (plan[r].known) begin
          g.status = plan[r].st;
          g.addr   = plan[r].g_addr;
          g.blocks = plan[r].g_blocks;
        end
        expected_grants.push_back(g);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      set_merge_mode(ph % 2);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        burst = $urandom_range(1, 24);
        for (int k = 0; k < burst && sent < PHASE_ITEMS; k++) begin
          pick_request(op, req, seg);
          send_request(op, req, seg, g);
          expected_grants.push_back(g);
          sent++;
        end
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap > 0) begin
          s_axis_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end

    s_axis_tvalid <= 1'b0;
    while (expected_grants.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
